[rtl/core/dcd_pkg.sv]
// Shared constants, types and twiddle table for the direct complex DFT core.
`default_nettype none

package dcd_pkg;

    // Transform size (power of two, 2..64) and derived widths
    localparam int POINTS    = 64;
    localparam int IDX_W     = $clog2(POINTS);
    localparam int SAMPLE_W  = 16;
    localparam int TWID_W    = 17;
    localparam int PROD_W    = SAMPLE_W + TWID_W;
    localparam int ACC_W     = 40;
    localparam int BIN_W     = 24;
    localparam int INDEX_W   = 6;
    localparam int FRAC_BITS = 15;

    // Twiddle table covers one full turn in 64 steps
    localparam int ROM_DEPTH = 64;
    localparam int ROM_AW    = 6;
    localparam int STRIDE    = ROM_DEPTH / POINTS;

    // First quadrant of sin(2*pi*r/64) * 32768, r = 0..16
    localparam logic signed [TWID_W-1:0] QUARTER_SINE [17] = '{
        17'sd0,     17'sd3212,  17'sd6393,  17'sd9512,
        17'sd12540, 17'sd15447, 17'sd18205, 17'sd20788,
        17'sd23170, 17'sd25330, 17'sd27246, 17'sd28899,
        17'sd30274, 17'sd31357, 17'sd32138, 17'sd32610,
        17'sd32768
    };

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WAIT,
        ST_RUN,
        ST_DRAIN
    } dcd_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load_en;
        logic [IDX_W-1:0] load_addr;
        logic             step_valid;
        logic             step_first;
        logic             step_last;
        logic [IDX_W-1:0] step_addr;
        logic [IDX_W-1:0] step_phase;
        logic [IDX_W-1:0] bin;
    } dcd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic bin_done;
    } dcd_status_t;

    // Sine of angle 2*pi*m/64 in Q2.15 (1.0 is 32768)
    function automatic logic signed [TWID_W-1:0] rom_sine(input logic [ROM_AW-1:0] m);
        logic [1:0]                quad;
        logic [3:0]                r;
        logic [4:0]                sel;
        logic signed [TWID_W-1:0]  v;
        quad = m[5:4];
        r    = m[3:0];
        sel  = quad[0] ? (5'd16 - {1'b0, r}) : {1'b0, r};
        v    = QUARTER_SINE[sel];
        return quad[1] ? -v : v;
    endfunction

    // Cosine of angle 2*pi*m/64 in Q2.15
    function automatic logic signed [TWID_W-1:0] rom_cosine(input logic [ROM_AW-1:0] m);
        return rom_sine(m + ROM_AW'(16));
    endfunction

endpackage

`default_nettype wire

[rtl/core/dcd_ctrl.sv]
// Controller state machine: sample loading, bin and step sequencing.
`default_nettype none

module dcd_ctrl
    import dcd_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    output logic        s_ready,
    output dcd_cmd_t    cmd,
    input  dcd_status_t status
);

    dcd_state_t       state_reg, state_next;
    logic [IDX_W-1:0] load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0] bin_reg, bin_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0] phase_reg, phase_next;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

    // Hold state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            bin_reg      <= '0;
            step_reg     <= '0;
            phase_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            bin_reg      <= bin_next;
            step_reg     <= step_next;
            phase_reg    <= phase_next;
        end
    end

    // Advance the sequence and issue datapath commands
    always_comb begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        bin_next       = bin_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.load_addr  = load_cnt_reg;
        cmd.step_addr  = step_reg;
        cmd.step_phase = phase_reg;
        cmd.bin        = bin_reg;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready     = 1'b1;
                cmd.load_en = s_valid;
                if (s_valid) begin
                    if (load_cnt_reg == LAST_IDX) begin
                        load_cnt_next = '0;
                        bin_next      = '0;
                        state_next    = ST_WAIT;
                    end else begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            ST_WAIT: begin
                // Start a bin only once the output register is free
                if (status.out_free) begin
                    step_next  = '0;
                    phase_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step_valid = 1'b1;
                cmd.step_first = (step_reg == '0);
                cmd.step_last  = (step_reg == LAST_IDX);
                step_next      = step_reg + 1'b1;
                phase_next     = phase_reg + bin_reg;
                if (step_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.bin_done) begin
                    if (bin_reg == LAST_IDX) begin
                        state_next = ST_LOAD;
                    end else begin
                        bin_next   = bin_reg + 1'b1;
                        state_next = ST_WAIT;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/dcd_datapath.sv]
// Datapath: sample store, twiddle lookup, complex multiply-accumulate, output register.
`default_nettype none

module dcd_datapath
    import dcd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic signed [15:0]   s_sample_real,
    input  wire logic signed [15:0]   s_sample_imag,
    input  dcd_cmd_t                  cmd,
    output dcd_status_t               status,
    output logic [INDEX_W-1:0]        m_bin_index,
    output logic signed [BIN_W-1:0]   m_bin_real,
    output logic signed [BIN_W-1:0]   m_bin_imag,
    output logic                      m_last_bin,
    output logic                      m_valid,
    input  wire logic                 m_ready
);

    // Sample store: real in the upper half, imaginary in the lower half
    logic [2*SAMPLE_W-1:0] store_mem [POINTS];
    logic [2*SAMPLE_W-1:0] rd_data_reg;

    // Stage 1: operands
    logic                       v1_reg, first1_reg, last1_reg;
    logic signed [TWID_W-1:0]   cos_reg, sin_reg;
    logic [ROM_AW-1:0]          rom_addr;

    // Stage 2: products
    logic                       v2_reg, first2_reg, last2_reg;
    logic signed [PROD_W-1:0]   p_rc_reg, p_is_reg, p_ic_reg, p_rs_reg;
    logic signed [SAMPLE_W-1:0] xr, xi;

    // Stage 3: accumulators
    logic signed [ACC_W-1:0]    acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]    acc_re_next, acc_im_next;
    logic signed [ACC_W-1:0]    base_re, base_im;
    logic                       done_reg;

    // Output register
    logic                       m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]         m_bin_index_reg;
    logic signed [BIN_W-1:0]    m_bin_real_reg, m_bin_imag_reg;
    logic                       m_last_bin_reg;
    logic signed [ACC_W-1:0]    rnd_re, rnd_im;

    // Write loaded words, read the addressed sample
    always_ff @(posedge aclk) begin
        if (cmd.load_en) begin
            store_mem[cmd.load_addr] <= {s_sample_real, s_sample_imag};
        end
        rd_data_reg <= store_mem[cmd.step_addr];
    end

    // Look up twiddles for this step
    assign rom_addr = ROM_AW'(32'(cmd.step_phase) * STRIDE);

    always_ff @(posedge aclk) begin
        cos_reg <= rom_cosine(rom_addr);
        sin_reg <= rom_sine(rom_addr);
    end

    // Form the four partial products
    assign xr = rd_data_reg[2*SAMPLE_W-1:SAMPLE_W];
    assign xi = rd_data_reg[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        p_rc_reg <= xr * cos_reg;
        p_is_reg <= xi * sin_reg;
        p_ic_reg <= xi * cos_reg;
        p_rs_reg <= xr * sin_reg;
    end

    // Accumulate; restart on the first step of a bin
    assign base_re     = first2_reg ? '0 : acc_re_reg;
    assign base_im     = first2_reg ? '0 : acc_im_reg;
    assign acc_re_next = base_re + ACC_W'(p_rc_reg) + ACC_W'(p_is_reg);
    assign acc_im_next = base_im + ACC_W'(p_ic_reg) - ACC_W'(p_rs_reg);

    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    // Advance step flags through the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            first1_reg <= 1'b0;
            last1_reg  <= 1'b0;
            v2_reg     <= 1'b0;
            first2_reg <= 1'b0;
            last2_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            v1_reg     <= cmd.step_valid;
            first1_reg <= cmd.step_first;
            last1_reg  <= cmd.step_last;
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
            done_reg   <= v2_reg && last2_reg;
        end
    end

    // Round to nearest, ties toward plus infinity
    assign rnd_re = acc_re_reg + ACC_W'(1 << (FRAC_BITS - 1));
    assign rnd_im = acc_im_reg + ACC_W'(1 << (FRAC_BITS - 1));

    // Hold the result word until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (done_reg) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_reg) begin
            m_bin_index_reg <= INDEX_W'(cmd.bin);
            m_bin_real_reg  <= rnd_re[FRAC_BITS +: BIN_W];
            m_bin_imag_reg  <= rnd_im[FRAC_BITS +: BIN_W];
            m_last_bin_reg  <= (cmd.bin == IDX_W'(POINTS - 1));
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_index = m_bin_index_reg;
    assign m_bin_real  = m_bin_real_reg;
    assign m_bin_imag  = m_bin_imag_reg;
    assign m_last_bin  = m_last_bin_reg;

    // Report status to the controller
    assign status.out_free = !m_valid_reg || m_ready;
    assign status.bin_done = done_reg;

endmodule

`default_nettype wire

[rtl/core/direct_complex_dft_core.sv]
// Top level of the direct complex DFT core: controller plus datapath.
//
//  channel | direction | words             | fields
//  s_      | in        | one per sample    | sample_real, sample_imag (Q1.15)
//  m_      | out       | POINTS per frame  | bin_index, bin_real, bin_imag, last_bin
//
// A sample word is taken whenever s_valid is high during loading; the first
// POINTS-1 words of a frame give no result. After the last word, each bin is
// computed with one shared complex multiply-accumulate, one step per cycle,
// plus start and pipeline drain. Sample words are accepted again once the last
// bin sits in the output register. A stalled output holds the next bin from
// starting. Reset clears control state only; no clearing pass.
`default_nettype none

module direct_complex_dft_core
    import dcd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [15:0]   s_sample_real,
    input  wire logic signed [15:0]   s_sample_imag,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [5:0]                m_bin_index,
    output logic signed [23:0]        m_bin_real,
    output logic signed [23:0]        m_bin_imag,
    output logic                      m_last_bin
);

    dcd_cmd_t    cmd;
    dcd_status_t status;

    // Sequence loading and computation
    dcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Store, multiply-accumulate and emit bins
    dcd_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_sample_real (s_sample_real),
        .s_sample_imag (s_sample_imag),
        .cmd           (cmd),
        .status        (status),
        .m_bin_index   (m_bin_index),
        .m_bin_real    (m_bin_real),
        .m_bin_imag    (m_bin_imag),
        .m_last_bin    (m_last_bin),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

endmodule

`default_nettype wire

[rtl/core/dcd_checker.sv]
// Port-level checks for the direct complex DFT core, bound to the top level.
`default_nettype none

module dcd_checker
    import dcd_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [5:0]  m_bin_index,
    input wire logic [23:0] m_bin_real,
    input wire logic [23:0] m_bin_imag,
    input wire logic        m_last_bin
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_index) &&
            $stable(m_bin_real) && $stable(m_bin_imag) && $stable(m_last_bin))
        else $error("stalled result word changed");

    // Flag only the final bin
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_bin == (m_bin_index == 6'(POINTS - 1))))
        else $error("last_bin does not match bin index");

    // Leave a gap after each bin but the last, while the next one is computed
    a_bin_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_bin |=> !m_valid)
        else $error("bins issued back to back");

    // Drop the result valid on reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind direct_complex_dft_core dcd_checker u_dcd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_bin_index (m_bin_index),
    .m_bin_real  (m_bin_real),
    .m_bin_imag  (m_bin_imag),
    .m_last_bin  (m_last_bin)
);

`default_nettype wire
